### hdl/dpd_pkg.sv
// Shared types, constants and helper functions of the DPD pair force accumulator.
`default_nettype none

package dpd_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int NEWTON_STEPS = 3;
    localparam int NSTEP_W      = $clog2(NEWTON_STEPS);
    localparam int E_BASE       = 2 * FRAC_BITS - 30;

    localparam int SH_W = 7;
    localparam logic [SH_W-1:0] SH_ZERO  = SH_W'(0);
    localparam logic [SH_W-1:0] SH_FRAC  = SH_W'(FRAC_BITS);
    localparam logic [SH_W-1:0] SH_HALF  = SH_W'(FRAC_BITS + 1);
    localparam logic [SH_W-1:0] SH_DFRAC = SH_W'(2 * FRAC_BITS);
    localparam logic [SH_W-1:0] SH_Q30   = SH_W'(30);
    localparam logic [SH_W-1:0] SH_Q31   = SH_W'(31);

    localparam logic [47:0] MAX48     = {1'b0, {47{1'b1}}};
    localparam logic [47:0] MIN48     = {1'b1, 47'b0};
    localparam logic [47:0] FAC_ONE   = 48'(64'd1 << FRAC_BITS);
    localparam logic [47:0] THREE_Q30 = 48'(64'd3 << 30);

    localparam logic [30:0] RST_CUTOFF     = 31'd65536;
    localparam logic [30:0] RST_INV_CUTOFF = 31'd65536;
    localparam logic [30:0] RST_REPULSION  = 31'd1638400;
    localparam logic [30:0] RST_FRICTION   = 31'd294912;
    localparam logic [30:0] RST_NOISE_GAIN = 31'd983040;
    localparam logic [16:0] RST_SPECIAL    = 17'd65536;

    typedef enum logic [2:0] {
        CFG_CUTOFF,
        CFG_INV_CUTOFF,
        CFG_REPULSION,
        CFG_FRICTION,
        CFG_NOISE_GAIN,
        CFG_SPECIAL_ONE,
        CFG_SPECIAL_TWO,
        CFG_SPECIAL_THREE
    } t_cfg_idx;

    // Multiply operations run on the shared multiplier, in program order.
    typedef enum logic [4:0] {
        OP_SQX, OP_SQY, OP_SQZ, OP_CUT,
        OP_Y2, OP_P, OP_YN, OP_S,
        OP_D1, OP_D2, OP_D3,
        OP_G, OP_GD, OP_N, OP_F1, OP_F2,
        OP_FX, OP_FY, OP_FZ,
        OP_Q, OP_E1, OP_E2
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_CHK,
        ST_NORM,
        ST_FIN,
        ST_ACC
    } t_state;

    typedef struct packed {
        logic load;
        logic mul_start;
        logic wb;
        logic norm_init;
        logic norm_step;
        logic seed;
        logic fin;
        logic acc;
        t_op  op;
    } t_dp_cmd;

    typedef struct packed {
        logic mul_done;
        logic in_range;
        logic rsq_zero;
        logic norm_ok;
        logic out_free;
    } t_dp_status;

    function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
        if (v > $signed({2'b00, MAX48}))
            return MAX48;
        else if (v < $signed({2'b11, MIN48}))
            return MIN48;
        else
            return v[47:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        if (v > $signed(48'sh0000_7FFF_FFFF))
            return 32'sh7FFF_FFFF;
        else if (v < $signed(48'shFFFF_8000_0000))
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [63:0] ext32(input logic signed [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic logic signed [63:0] ext48(input logic signed [47:0] v);
        return {{16{v[47]}}, v};
    endfunction

    function automatic logic signed [49:0] w50(input logic signed [47:0] v);
        return {{2{v[47]}}, v};
    endfunction

    // Initial 1/sqrt estimate, indexed by the top four bits of the Q2.30 mantissa.
    function automatic logic [15:0] seed_lookup(input logic [3:0] idx);
        logic [15:0] v;
        unique case (idx)
            4'd0, 4'd1, 4'd2, 4'd3: v = 16'd32767;
            4'd4:  v = 16'd30894;
            4'd5:  v = 16'd27945;
            4'd6:  v = 16'd25705;
            4'd7:  v = 16'd23930;
            4'd8:  v = 16'd22479;
            4'd9:  v = 16'd21263;
            4'd10: v = 16'd20225;
            4'd11: v = 16'd19326;
            4'd12: v = 16'd18536;
            4'd13: v = 16'd17837;
            4'd14: v = 16'd17211;
            4'd15: v = 16'd16646;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### hdl/dpd_mul.sv
// Shared multi-cycle signed multiplier: four 32x32 partial products, shift, saturate.
`default_nettype none

module dpd_mul (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic signed [63:0]          i_a,
    input  wire logic signed [63:0]          i_b,
    input  wire logic [dpd_pkg::SH_W-1:0]    i_sh,
    output logic                             o_done,
    output logic signed [47:0]               o_res,
    output logic [63:0]                      o_raw
);
    import dpd_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [2:0]        r_k;
    logic [63:0]       r_ua;
    logic [63:0]       r_ub;
    logic              r_neg;
    logic [SH_W-1:0]   r_sh;
    logic [127:0]      r_acc;
    logic signed [47:0] r_res;
    logic [63:0]       r_raw;

    logic [31:0]  w_ah;
    logic [31:0]  w_bh;
    logic [63:0]  w_pp;
    logic [127:0] w_ppw;
    logic [127:0] w_shifted;
    logic [127:0] w_lim;
    logic [47:0]  w_mag;

    always_comb begin
        w_ah = r_k[1] ? r_ua[63:32] : r_ua[31:0];
        w_bh = r_k[0] ? r_ub[63:32] : r_ub[31:0];
        w_pp = {32'b0, w_ah} * {32'b0, w_bh};
        unique case (r_k[1:0])
            2'b00:        w_ppw = {64'b0, w_pp};
            2'b01, 2'b10: w_ppw = {32'b0, w_pp, 32'b0};
            2'b11:        w_ppw = {w_pp, 64'b0};
        endcase
        w_shifted = r_acc >> r_sh;
        w_lim     = r_neg ? {80'b0, MIN48} : {80'b0, MAX48};
        w_mag     = (w_shifted > w_lim) ? w_lim[47:0] : w_shifted[47:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= 3'd0;
            end else if (r_busy) begin
                if (!r_k[2]) begin
                    r_k <= r_k + 3'd1;
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ua  <= i_a[63] ? 64'd0 - i_a : i_a;
            r_ub  <= i_b[63] ? 64'd0 - i_b : i_b;
            r_neg <= i_a[63] ^ i_b[63];
            r_sh  <= i_sh;
            r_acc <= 128'd0;
        end else if (r_busy) begin
            if (!r_k[2]) begin
                r_acc <= r_acc + w_ppw;
            end else begin
                r_res <= r_neg ? 48'd0 - w_mag : w_mag;
                r_raw <= r_acc[63:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;
    assign o_raw  = r_raw;

endmodule

`default_nettype wire

### hdl/dpd_ctrl.sv
// Controller state machine that sequences the pair force computation.
`default_nettype none

module dpd_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire dpd_pkg::t_dp_status   i_status,
    output dpd_pkg::t_dp_cmd           o_cmd
);
    import dpd_pkg::*;

    t_state             r_state, n_state;
    t_op                r_op, n_op;
    logic [NSTEP_W-1:0] r_nstep, n_nstep;

    function automatic t_op next_op(input t_op op);
        t_op v;
        unique case (op)
            OP_SQX:  v = OP_SQY;
            OP_SQY:  v = OP_SQZ;
            OP_SQZ:  v = OP_CUT;
            OP_Y2:   v = OP_P;
            OP_P:    v = OP_YN;
            OP_D1:   v = OP_D2;
            OP_D2:   v = OP_D3;
            OP_D3:   v = OP_G;
            OP_G:    v = OP_GD;
            OP_GD:   v = OP_N;
            OP_N:    v = OP_F1;
            OP_F1:   v = OP_F2;
            OP_F2:   v = OP_FX;
            OP_FX:   v = OP_FY;
            OP_FY:   v = OP_FZ;
            OP_FZ:   v = OP_Q;
            OP_Q:    v = OP_E1;
            OP_E1:   v = OP_E2;
            default: v = op;
        endcase
        return v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_SQX;
            r_nstep <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_nstep <= n_nstep;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_nstep    = r_nstep;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.op   = r_op;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_op       = OP_SQX;
                    n_nstep    = '0;
                    n_state    = ST_MUL_GO;
                end
            end
            ST_MUL_GO: begin
                o_cmd.mul_start = 1'b1;
                n_state         = ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
                if (i_status.mul_done) begin
                    o_cmd.wb = 1'b1;
                    priority case (r_op)
                        OP_CUT: n_state = ST_CHK;
                        OP_S:   n_state = ST_FIN;
                        OP_E2:  n_state = ST_ACC;
                        OP_YN: begin
                            n_state = ST_MUL_GO;
                            if (r_nstep == NSTEP_W'(NEWTON_STEPS - 1)) begin
                                n_op    = OP_S;
                                n_nstep = '0;
                            end else begin
                                n_op    = OP_Y2;
                                n_nstep = r_nstep + NSTEP_W'(1);
                            end
                        end
                        default: begin
                            n_op    = next_op(r_op);
                            n_state = ST_MUL_GO;
                        end
                    endcase
                end
            end
            ST_CHK: begin
                priority if (!i_status.in_range) begin
                    n_state = ST_ACC;
                end else if (i_status.rsq_zero) begin
                    n_state = ST_FIN;
                end else begin
                    o_cmd.norm_init = 1'b1;
                    n_state         = ST_NORM;
                end
            end
            ST_NORM: begin
                // Shift the mantissa two bits a cycle into [1,4).
                if (i_status.norm_ok) begin
                    o_cmd.seed = 1'b1;
                    n_op       = OP_Y2;
                    n_state    = ST_MUL_GO;
                end else begin
                    o_cmd.norm_step = 1'b1;
                end
            end
            ST_FIN: begin
                o_cmd.fin = 1'b1;
                n_op      = OP_D1;
                n_state   = ST_MUL_GO;
            end
            ST_ACC: begin
                // Hold until the result register is free.
                if (i_status.out_free) begin
                    o_cmd.acc = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

### hdl/dpd_datapath.sv
// Datapath: configuration, operand registers, shared multiplier, totals and result register.
`default_nettype none

module dpd_datapath (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire dpd_pkg::t_dp_cmd      i_cmd,
    output dpd_pkg::t_dp_status        o_status,
    input  wire logic                  i_cfg_wen,
    input  wire logic [2:0]            i_cfg_index,
    input  wire logic [30:0]           i_cfg_data,
    input  wire logic [223:0]          i_in_data,
    input  wire logic [1:0]            i_in_class,
    input  wire logic                  i_in_last,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output logic [319:0]               o_out_data,
    output logic                       o_out_range,
    output logic                       o_out_last
);
    import dpd_pkg::*;

    logic [30:0] r_cut, r_icut, r_a0, r_gamma, r_noise;
    logic [16:0] r_sp1, r_sp2, r_sp3;

    logic signed [31:0] r_dx, r_dy, r_dz, r_dvx, r_dvy, r_dvz, r_gn;
    logic [1:0]         r_cls;
    logic               r_last;

    logic [63:0]        r_rsq, r_cutsq, r_m;
    logic [5:0]         r_h2;
    logic signed [47:0] r_y, r_y2, r_h, r_s, r_r, r_iwd, r_dot, r_tg, r_inner;
    logic signed [47:0] r_tf, r_fpair, r_q, r_te;
    logic signed [31:0] r_pfx, r_pfy, r_pfz, r_pe;

    logic signed [47:0] r_sum_fx, r_sum_fy, r_sum_fz, r_sum_e;
    logic               r_ovalid;
    logic signed [31:0] r_o_pfx, r_o_pfy, r_o_pfz, r_o_pe;
    logic signed [47:0] r_o_tfx, r_o_tfy, r_o_tfz, r_o_te;
    logic               r_o_inr, r_o_last;

    logic signed [63:0]  w_a, w_b;
    logic [SH_W-1:0]     w_sh;
    logic                w_mul_done;
    logic signed [47:0]  w_res;
    logic [63:0]         w_raw;
    logic signed [47:0]  w_fac;
    logic                w_inr;

    logic [63:0]         w_sl, w_rr, w_yl, w_yr;
    logic signed [7:0]   w_e, w_ne;
    logic [47:0]         w_r, w_rinv;
    logic signed [49:0]  w_diff;
    logic signed [47:0]  w_q0;
    logic signed [47:0]  w_nfx, w_nfy, w_nfz, w_ne_sum;

    always_comb begin
        unique case (r_cls)
            2'd0: w_fac = FAC_ONE;
            2'd1: w_fac = {31'b0, r_sp1};
            2'd2: w_fac = {31'b0, r_sp2};
            2'd3: w_fac = {31'b0, r_sp3};
        endcase
    end

    assign w_inr = r_rsq < r_cutsq;

    // Operand select for the shared multiplier.
    always_comb begin
        w_a  = '0;
        w_b  = '0;
        w_sh = SH_FRAC;
        unique case (i_cmd.op)
            OP_SQX: begin w_a = ext32(r_dx); w_b = ext32(r_dx); w_sh = SH_ZERO; end
            OP_SQY: begin w_a = ext32(r_dy); w_b = ext32(r_dy); w_sh = SH_ZERO; end
            OP_SQZ: begin w_a = ext32(r_dz); w_b = ext32(r_dz); w_sh = SH_ZERO; end
            OP_CUT: begin w_a = {33'b0, r_cut}; w_b = {33'b0, r_cut}; w_sh = SH_ZERO; end
            OP_Y2:  begin w_a = ext48(r_y); w_b = ext48(r_y); w_sh = SH_Q30; end
            OP_P:   begin w_a = r_m; w_b = ext48(r_y2); w_sh = SH_Q30; end
            OP_YN:  begin w_a = ext48(r_y); w_b = ext48(r_h); w_sh = SH_Q31; end
            OP_S:   begin w_a = r_m; w_b = ext48(r_y); w_sh = SH_Q30; end
            OP_D1:  begin w_a = ext32(r_dx); w_b = ext32(r_dvx); end
            OP_D2:  begin w_a = ext32(r_dy); w_b = ext32(r_dvy); end
            OP_D3:  begin w_a = ext32(r_dz); w_b = ext32(r_dvz); end
            OP_G:   begin w_a = ext48(r_iwd); w_b = {33'b0, r_gamma}; end
            OP_GD:  begin w_a = ext48(r_tg); w_b = ext48(r_dot); end
            OP_N:   begin w_a = {33'b0, r_noise}; w_b = ext32(r_gn); end
            OP_F1:  begin w_a = ext48(r_inner); w_b = ext48(w_fac); end
            OP_F2:  begin w_a = ext48(r_tf); w_b = ext48(r_iwd); end
            OP_FX:  begin w_a = ext48(r_fpair); w_b = ext32(r_dx); end
            OP_FY:  begin w_a = ext48(r_fpair); w_b = ext32(r_dy); end
            OP_FZ:  begin w_a = ext48(r_fpair); w_b = ext32(r_dz); end
            OP_Q:   begin w_a = r_rsq; w_b = {33'b0, r_icut}; w_sh = SH_DFRAC; end
            OP_E1:  begin w_a = {33'b0, r_a0}; w_b = ext48(r_q); w_sh = SH_HALF; end
            OP_E2:  begin w_a = ext48(r_te); w_b = ext48(w_fac); end
            default: begin w_a = '0; w_b = '0; end
        endcase
    end

    dpd_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_sh    (w_sh),
        .o_done  (w_mul_done),
        .o_res   (w_res),
        .o_raw   (w_raw)
    );

    // Scale the normalized results back: r = m*y and 1/r = y.
    always_comb begin
        w_sl   = {16'b0, r_s} << r_h2;
        w_rr   = w_sl >> 30;
        w_r    = (w_rr > {16'b0, MAX48}) ? MAX48 : w_rr[47:0];
        w_e    = 8'(E_BASE) - {2'b00, r_h2};
        w_ne   = 8'sd0 - w_e;
        w_yl   = {16'b0, r_y} << w_e[6:0];
        w_yr   = {16'b0, r_y} >> w_ne[6:0];
        if (w_e[7])
            w_rinv = w_yr[47:0];
        else
            w_rinv = (w_yl > {16'b0, MAX48}) ? MAX48 : w_yl[47:0];
        w_diff = $signed({2'b00, w_rinv}) - $signed({19'b0, r_icut});
        w_q0   = sat48($signed({19'b0, r_cut}) - $signed({r_r[47], r_r, 1'b0}));
    end

    always_comb begin
        w_nfx    = sat48(w50(r_sum_fx) + w50(48'(r_pfx)));
        w_nfy    = sat48(w50(r_sum_fy) + w50(48'(r_pfy)));
        w_nfz    = sat48(w50(r_sum_fz) + w50(48'(r_pfz)));
        w_ne_sum = sat48(w50(r_sum_e) + w50(48'(r_pe)));
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut   <= RST_CUTOFF;
            r_icut  <= RST_INV_CUTOFF;
            r_a0    <= RST_REPULSION;
            r_gamma <= RST_FRICTION;
            r_noise <= RST_NOISE_GAIN;
            r_sp1   <= RST_SPECIAL;
            r_sp2   <= RST_SPECIAL;
            r_sp3   <= RST_SPECIAL;
        end else if (i_cfg_wen) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CUTOFF:        r_cut   <= i_cfg_data;
                CFG_INV_CUTOFF:    r_icut  <= i_cfg_data;
                CFG_REPULSION:     r_a0    <= i_cfg_data;
                CFG_FRICTION:      r_gamma <= i_cfg_data;
                CFG_NOISE_GAIN:    r_noise <= i_cfg_data;
                CFG_SPECIAL_ONE:   r_sp1   <= i_cfg_data[16:0];
                CFG_SPECIAL_TWO:   r_sp2   <= i_cfg_data[16:0];
                CFG_SPECIAL_THREE: r_sp3   <= i_cfg_data[16:0];
            endcase
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dx   <= i_in_data[31:0];
            r_dy   <= i_in_data[63:32];
            r_dz   <= i_in_data[95:64];
            r_dvx  <= i_in_data[127:96];
            r_dvy  <= i_in_data[159:128];
            r_dvz  <= i_in_data[191:160];
            r_gn   <= i_in_data[223:192];
            r_cls  <= i_in_class;
            r_last <= i_in_last;
            r_pfx  <= '0;
            r_pfy  <= '0;
            r_pfz  <= '0;
            r_pe   <= '0;
        end
        if (i_cmd.norm_init) begin
            r_m  <= r_rsq;
            r_h2 <= 6'd15;
        end
        if (i_cmd.norm_step) begin
            if (r_m[63:32] != 32'd0) begin
                r_m  <= r_m >> 2;
                r_h2 <= r_h2 + 6'd1;
            end else begin
                r_m  <= r_m << 2;
                r_h2 <= r_h2 - 6'd1;
            end
        end
        if (i_cmd.seed)
            r_y <= {17'b0, seed_lookup(r_m[31:28]), 15'b0};
        if (i_cmd.fin) begin
            if (r_rsq == 64'd0) begin
                r_r   <= '0;
                r_iwd <= '0;
            end else begin
                r_r   <= w_r;
                // Force a weight that rounding drove negative to zero.
                r_iwd <= w_diff[49] ? 48'sd0 : w_diff[47:0];
            end
        end
        if (i_cmd.wb) begin
            unique case (i_cmd.op)
                OP_SQX:  r_rsq   <= w_raw;
                OP_SQY:  r_rsq   <= r_rsq + w_raw;
                OP_SQZ:  r_rsq   <= r_rsq + w_raw;
                OP_CUT:  r_cutsq <= w_raw;
                OP_Y2:   r_y2    <= w_res;
                OP_P:    r_h     <= (w_res > $signed(THREE_Q30)) ? 48'sd0 : THREE_Q30 - w_res;
                OP_YN:   r_y     <= w_res;
                OP_S:    r_s     <= w_res;
                OP_D1:   r_dot   <= w_res;
                OP_D2:   r_dot   <= sat48(w50(r_dot) + w50(w_res));
                OP_D3:   r_dot   <= sat48(w50(r_dot) + w50(w_res));
                OP_G:    r_tg    <= w_res;
                OP_GD:   r_inner <= sat48($signed({19'b0, r_a0}) - w50(w_res));
                OP_N:    r_inner <= sat48(w50(r_inner) + w50(w_res));
                OP_F1:   r_tf    <= w_res;
                OP_F2:   r_fpair <= w_res;
                OP_FX:   r_pfx   <= sat32(w_res);
                OP_FY:   r_pfy   <= sat32(w_res);
                OP_FZ:   r_pfz   <= sat32(w_res);
                OP_Q:    r_q     <= sat48(w50(w_q0) + w50(w_res));
                OP_E1:   r_te    <= w_res;
                OP_E2:   r_pe    <= sat32(w_res);
                default: r_te    <= r_te;
            endcase
        end
    end

    // Per-atom totals and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_fx <= '0;
            r_sum_fy <= '0;
            r_sum_fz <= '0;
            r_sum_e  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.acc) begin
                r_ovalid <= 1'b1;
                if (r_last) begin
                    r_sum_fx <= '0;
                    r_sum_fy <= '0;
                    r_sum_fz <= '0;
                    r_sum_e  <= '0;
                end else begin
                    r_sum_fx <= w_nfx;
                    r_sum_fy <= w_nfy;
                    r_sum_fz <= w_nfz;
                    r_sum_e  <= w_ne_sum;
                end
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_o_pfx  <= r_pfx;
            r_o_pfy  <= r_pfy;
            r_o_pfz  <= r_pfz;
            r_o_pe   <= r_pe;
            r_o_tfx  <= w_nfx;
            r_o_tfy  <= w_nfy;
            r_o_tfz  <= w_nfz;
            r_o_te   <= w_ne_sum;
            r_o_inr  <= w_inr;
            r_o_last <= r_last;
        end
    end

    assign o_status.mul_done = w_mul_done;
    assign o_status.in_range = w_inr;
    assign o_status.rsq_zero = (r_rsq == 64'd0);
    assign o_status.norm_ok  = (r_m[63:32] == 32'd0) && (r_m[31:30] != 2'b00);
    assign o_status.out_free = !r_ovalid || i_out_ready;

    assign o_out_valid = r_ovalid;
    assign o_out_data  = {r_o_te, r_o_tfz, r_o_tfy, r_o_tfx, r_o_pe, r_o_pfz, r_o_pfy, r_o_pfx};
    assign o_out_range = r_o_inr;
    assign o_out_last  = r_o_last;

endmodule

`default_nettype wire

### hdl/dpd_pair_force_accumulator.sv
// Top level of the DPD pair force accumulator: controller plus datapath.
//
// One neighbour pair enters per transfer and leaves as one result transfer with the pair force,
// pair energy and running per-atom totals; totals clear after a transfer marked last. All
// products go through one shared 32x32 multiplier that builds each product from four partial
// products. A pair outside the cutoff takes four multiplies plus the accept, range check and
// accumulate steps. A pair at zero distance skips the 1/sqrt and takes 18 multiplies. Any other
// pair inside takes 19 + 3*NEWTON_STEPS multiplies plus the accept, range check, normalization
// of the 1/sqrt mantissa, scaling and accumulate steps.
// The next pair is taken while a finished result still waits in the output register.
`default_nettype none

module dpd_pair_force_accumulator (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // tdata: dx, dy, dz, dvx, dvy, dvz, gauss_noise (32 bits each)
    input  wire logic [223:0]  i_s_axis_tdata,
    // tuser: bond_class
    input  wire logic [1:0]    i_s_axis_tuser,
    input  wire logic          i_s_axis_tlast,
    input  wire logic          i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    // tdata: pair_fx, pair_fy, pair_fz, pair_energy (32 bits each),
    //        total_fx, total_fy, total_fz, total_energy (48 bits each)
    output logic [319:0]       o_m_axis_tdata,
    // tuser: in_range
    output logic               o_m_axis_tuser,
    output logic               o_m_axis_tlast,
    output logic               o_m_axis_tvalid,
    input  wire logic          i_m_axis_tready,
    input  wire logic          i_cfg_wen,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [30:0]   i_cfg_data
);
    import dpd_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    dpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    dpd_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_s_axis_tdata),
        .i_in_class  (i_s_axis_tuser),
        .i_in_last   (i_s_axis_tlast),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata),
        .o_out_range (o_m_axis_tuser),
        .o_out_last  (o_m_axis_tlast)
    );

endmodule

`default_nettype wire
